// ===== hdl/pbsa_pkg.sv =====
`default_nettype none

package pbsa_pkg;

    // Default sizing
    localparam int NUM_PAGES_DEF = 64;
    localparam int MAX_SLOTS_DEF = 512;

    // Field widths
    localparam int FUNC_W   = 1;
    localparam int SIZE_W   = 13;
    localparam int PGIDX_W  = 6;
    localparam int SLIDX_W  = 9;
    localparam int STAT_W   = 2;
    localparam int SLOTS_W  = 10;
    localparam int HDR_W    = 3;
    localparam int CFG_W    = 13;
    localparam int CFGIX_W  = 2;
    localparam int NCNT_W   = 13;
    localparam int IN_DW    = 32;
    localparam int OUT_DW   = 24;

    // Search granule
    localparam int CHUNK_W  = 64;
    localparam int BYTE_BITS = 8;

    // Register indexes
    localparam logic [CFGIX_W-1:0] REG_OBJECT_SIZE  = 2'd0;
    localparam logic [CFGIX_W-1:0] REG_SLOTS_IN_USE = 2'd1;
    localparam logic [CFGIX_W-1:0] REG_HEADER_SLOTS = 2'd2;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_BIG = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PAGE = 2'd2;

    typedef enum logic [1:0] {
        RES_ALLOC_OK,
        RES_FREE,
        RES_TOO_BIG,
        RES_NO_PAGE
    } res_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_req;
        logic      stk_rd;
        logic      page_from_stk;
        logic      row_rd;
        logic      row_load;
        logic      srch_start;
        logic      set_bit;
        logic      mark_full_pop;
        logic      clr_bit;
        logic      fresh_take;
        logic      out_load;
        res_kind_t res;
    } pbsa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_free;
        logic free_ok;
        logic too_big;
        logic count_nz;
        logic fresh_avail;
        logic srch_busy;
        logic srch_found;
        logic out_free;
    } pbsa_stat_t;

endpackage

`default_nettype wire

// ===== hdl/pbsa_ram.sv =====
`default_nettype none

module pbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/pbsa_ctrl.sv =====
`default_nettype none

module pbsa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pbsa_pkg::pbsa_stat_t st,
    output pbsa_pkg::pbsa_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_A_TOP,
        S_A_STK,
        S_A_RD,
        S_A_LOAD,
        S_A_SRCH,
        S_A_CHK,
        S_F_WAIT,
        S_F_LOAD,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    pbsa_pkg::res_kind_t res_reg, res_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st.is_free)
                begin
                    res_next = pbsa_pkg::RES_FREE;
                    if (st.free_ok)
                    begin
                        cmd.row_rd = 1'b1;
                        state_next = S_F_WAIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (st.too_big)
                begin
                    res_next   = pbsa_pkg::RES_TOO_BIG;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_TOP;
                end
            end
            S_A_TOP:
            begin
                if (st.count_nz)
                begin
                    cmd.stk_rd = 1'b1;
                    state_next = S_A_STK;
                end
                else if (st.fresh_avail)
                begin
                    cmd.fresh_take = 1'b1;
                    res_next       = pbsa_pkg::RES_ALLOC_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    res_next   = pbsa_pkg::RES_NO_PAGE;
                    state_next = S_DONE;
                end
            end
            S_A_STK:
            begin
                cmd.page_from_stk = 1'b1;
                state_next        = S_A_RD;
            end
            S_A_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = S_A_LOAD;
            end
            S_A_LOAD:
            begin
                cmd.row_load   = 1'b1;
                cmd.srch_start = 1'b1;
                state_next     = S_A_SRCH;
            end
            S_A_SRCH:
            begin
                if (!st.srch_busy)
                begin
                    if (st.srch_found)
                    begin
                        cmd.set_bit    = 1'b1;
                        cmd.srch_start = 1'b1;
                        state_next     = S_A_CHK;
                    end
                    else
                    begin
                        cmd.mark_full_pop = 1'b1;
                        state_next        = S_A_TOP;
                    end
                end
            end
            S_A_CHK:
            begin
                if (!st.srch_busy)
                begin
                    cmd.mark_full_pop = !st.srch_found;
                    res_next          = pbsa_pkg::RES_ALLOC_OK;
                    state_next        = S_DONE;
                end
            end
            S_F_WAIT:
            begin
                state_next = S_F_LOAD;
            end
            S_F_LOAD:
            begin
                cmd.clr_bit = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= pbsa_pkg::RES_FREE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pbsa_dp.sv =====
`default_nettype none

module pbsa_dp #(
    parameter int NUM_PAGES = pbsa_pkg::NUM_PAGES_DEF,
    parameter int MAX_SLOTS = pbsa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pbsa_pkg::CFGIX_W-1:0]       cfg_index,
    input  wire logic [pbsa_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [pbsa_pkg::FUNC_W-1:0]        in_func,
    input  wire logic [pbsa_pkg::SIZE_W-1:0]        in_req_size,
    input  wire logic [pbsa_pkg::PGIDX_W-1:0]       in_page,
    input  wire logic [pbsa_pkg::SLIDX_W-1:0]       in_slot,
    input  wire pbsa_pkg::pbsa_cmd_t                cmd,
    output pbsa_pkg::pbsa_stat_t                    st,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [pbsa_pkg::STAT_W-1:0]             out_status,
    output logic [pbsa_pkg::PGIDX_W-1:0]            out_page,
    output logic [pbsa_pkg::SLIDX_W-1:0]            out_slot
);

    localparam int CW     = pbsa_pkg::CHUNK_W;
    localparam int NCHUNK = (MAX_SLOTS + CW - 1) / CW;
    localparam int ROW_W  = NCHUNK * CW;
    localparam int SLOT_W = $clog2(ROW_W);
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int POS_W  = $clog2(CW);
    localparam int NW     = pbsa_pkg::NCNT_W;

    // Configuration registers
    logic [pbsa_pkg::SIZE_W-1:0]  obj_size_reg;
    logic [pbsa_pkg::SLOTS_W-1:0] slots_reg;
    logic [pbsa_pkg::HDR_W-1:0]   hdr_reg;

    // Latched request
    logic                          func_reg;
    logic [pbsa_pkg::SIZE_W-1:0]   req_reg;
    logic [pbsa_pkg::PGIDX_W-1:0]  pg_reg;
    logic [pbsa_pkg::SLIDX_W-1:0]  sl_reg;

    // Allocator state
    logic [NUM_PAGES-1:0] full_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     fresh_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [ROW_W-1:0]     row_reg;

    // Search unit
    logic                 srch_busy_reg;
    logic                 srch_found_reg;
    logic [SLOT_W-1:0]    srch_slot_reg;
    logic [CH_W-1:0]      chunk_reg;

    // Output beat
    logic                        out_valid_reg;
    logic [pbsa_pkg::STAT_W-1:0] out_status_reg;
    logic [pbsa_pkg::PGIDX_W-1:0] out_page_reg;
    logic [pbsa_pkg::SLIDX_W-1:0] out_slot_reg;

    // Memories
    logic              row_we;
    logic [PAGE_W-1:0] row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [PAGE_W-1:0] row_raddr;
    logic [ROW_W-1:0]  row_rdata;
    logic              stk_we;
    logic [PAGE_W-1:0] stk_waddr;
    logic [PAGE_W-1:0] stk_wdata;
    logic [PAGE_W-1:0] stk_raddr;
    logic [PAGE_W-1:0] stk_rdata;

    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     n_trunc;
    logic              fresh_full;
    logic [ROW_W-1:0]  hdr_mask;
    logic [CW-1:0]     chunk_free;
    logic              chunk_any;
    logic [POS_W-1:0]  chunk_pos;
    logic              do_push;
    logic [PAGE_W-1:0] push_page;
    logic [SLOT_W-1:0] free_slot;

    pbsa_ram #(.WIDTH(ROW_W), .DEPTH(NUM_PAGES)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    pbsa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Effective slot count: round down to bytes, clamp to 8..MAX_SLOTS
    always_comb
    begin
        n_trunc = NW'({slots_reg[pbsa_pkg::SLOTS_W-1:3], 3'b000});
        if (n_trunc < NW'(pbsa_pkg::BYTE_BITS))
        begin
            n_eff = NW'(pbsa_pkg::BYTE_BITS);
        end
        else if (n_trunc > NW'(MAX_SLOTS))
        begin
            n_eff = NW'(MAX_SLOTS);
        end
        else
        begin
            n_eff = n_trunc;
        end
    end

    assign fresh_full = (n_eff <= NW'({1'b0, hdr_reg} + 4'd1));
    assign free_slot  = SLOT_W'(sl_reg);

    // Header slots of a fresh page
    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            hdr_mask[i] = (i <= int'(hdr_reg));
        end
    end

    // Free slots of the current chunk below the effective count
    always_comb
    begin
        for (int j = 0; j < CW; j++)
        begin
            chunk_free[j] = !row_reg[int'(chunk_reg) * CW + j]
                            && ((int'(chunk_reg) * CW + j) < int'(n_eff));
        end
        chunk_any = |chunk_free;
        chunk_pos = '0;
        for (int j = CW - 1; j >= 0; j--)
        begin
            if (chunk_free[j])
            begin
                chunk_pos = POS_W'(j);
            end
        end
    end

    // Memory addressing
    assign stk_raddr = PAGE_W'(count_reg - CNT_W'(1));
    assign row_raddr = cmd.clr_bit ? page_reg : page_reg;
    assign push_page = cmd.fresh_take ? PAGE_W'(fresh_reg) : page_reg;
    assign do_push   = (cmd.fresh_take && !fresh_full)
                       || (cmd.clr_bit && full_reg[page_reg]
                           && (count_reg < CNT_W'(NUM_PAGES)));
    assign stk_we    = do_push;
    assign stk_waddr = PAGE_W'(count_reg);
    assign stk_wdata = push_page;

    always_comb
    begin
        row_we    = cmd.set_bit || cmd.clr_bit || cmd.fresh_take;
        row_waddr = cmd.fresh_take ? PAGE_W'(fresh_reg) : page_reg;
        row_wdata = row_reg;
        if (cmd.fresh_take)
        begin
            row_wdata = hdr_mask;
        end
        else if (cmd.clr_bit)
        begin
            row_wdata = row_rdata;
            row_wdata[free_slot] = 1'b0;
        end
        else
        begin
            row_wdata[srch_slot_reg] = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_size_reg <= pbsa_pkg::SIZE_W'(8);
            slots_reg    <= pbsa_pkg::SLOTS_W'(512);
            hdr_reg      <= pbsa_pkg::HDR_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbsa_pkg::REG_OBJECT_SIZE:  obj_size_reg <= cfg_data;
                pbsa_pkg::REG_SLOTS_IN_USE: slots_reg <= cfg_data[pbsa_pkg::SLOTS_W-1:0];
                pbsa_pkg::REG_HEADER_SLOTS: hdr_reg <= cfg_data[pbsa_pkg::HDR_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Request, page and row registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= in_func;
            req_reg  <= in_req_size;
            pg_reg   <= in_page;
            sl_reg   <= in_slot;
            page_reg <= PAGE_W'(in_page);
        end
        else if (cmd.page_from_stk)
        begin
            page_reg <= stk_rdata;
        end
        else if (cmd.fresh_take)
        begin
            page_reg <= PAGE_W'(fresh_reg);
        end
        if (cmd.row_load)
        begin
            row_reg <= row_rdata;
        end
        else if (cmd.set_bit)
        begin
            row_reg[srch_slot_reg] <= 1'b1;
        end
        if (cmd.set_bit)
        begin
            slot_reg <= srch_slot_reg;
        end
        else if (cmd.fresh_take)
        begin
            slot_reg <= SLOT_W'(hdr_reg);
        end
    end

    // Full flags, stack depth and fresh page count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            if (cmd.mark_full_pop)
            begin
                full_reg[page_reg] <= 1'b1;
                count_reg          <= count_reg - CNT_W'(1);
            end
            if (cmd.fresh_take)
            begin
                full_reg[PAGE_W'(fresh_reg)] <= fresh_full;
                fresh_reg                    <= fresh_reg + CNT_W'(1);
            end
            if (cmd.clr_bit && do_push)
            begin
                full_reg[page_reg] <= 1'b0;
            end
            if (do_push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // First-free search, one chunk per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_busy_reg  <= 1'b0;
            srch_found_reg <= 1'b0;
            chunk_reg      <= '0;
        end
        else if (cmd.srch_start)
        begin
            srch_busy_reg  <= 1'b1;
            srch_found_reg <= 1'b0;
            chunk_reg      <= '0;
        end
        else if (srch_busy_reg)
        begin
            if (chunk_any)
            begin
                srch_busy_reg  <= 1'b0;
                srch_found_reg <= 1'b1;
            end
            else if (chunk_reg == CH_W'(NCHUNK - 1))
            begin
                srch_busy_reg <= 1'b0;
            end
            else
            begin
                chunk_reg <= chunk_reg + CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (srch_busy_reg && chunk_any)
        begin
            srch_slot_reg <= SLOT_W'(int'(chunk_reg) * CW + int'(chunk_pos));
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_page_reg <= '0;
            out_slot_reg <= '0;
            case (cmd.res)
                pbsa_pkg::RES_ALLOC_OK:
                begin
                    out_status_reg <= pbsa_pkg::ST_OK;
                    out_page_reg   <= pbsa_pkg::PGIDX_W'(page_reg);
                    out_slot_reg   <= pbsa_pkg::SLIDX_W'(slot_reg);
                end
                pbsa_pkg::RES_TOO_BIG: out_status_reg <= pbsa_pkg::ST_TOO_BIG;
                pbsa_pkg::RES_NO_PAGE: out_status_reg <= pbsa_pkg::ST_NO_PAGE;
                default:               out_status_reg <= pbsa_pkg::ST_OK;
            endcase
        end
    end

    // Status toward the controller
    assign st.is_free     = (func_reg == pbsa_pkg::FUNC_FREE);
    assign st.free_ok     = (32'(pg_reg) < 32'(NUM_PAGES))
                            && (32'(pg_reg) < 32'(fresh_reg))
                            && (NW'(sl_reg) < n_eff);
    assign st.too_big     = (req_reg > obj_size_reg);
    assign st.count_nz    = (count_reg != '0);
    assign st.fresh_avail = (fresh_reg < CNT_W'(NUM_PAGES));
    assign st.srch_busy   = srch_busy_reg;
    assign st.srch_found  = srch_found_reg;
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_page   = out_page_reg;
    assign out_slot   = out_slot_reg;

endmodule

`default_nettype wire

// ===== hdl/paged_bitmap_slot_allocator_unit.sv =====
`default_nettype none

// Slab-style slot allocator over NUM_PAGES pages of up to MAX_SLOTS slots.
// Each input beat is an allocate (tuser 0) or a free (tuser 1) and yields
// exactly one output beat with status, page and slot. An allocate takes the
// lowest free slot of the page on top of the partial-page stack, or a fresh
// page when the stack is empty; exhausted pages are popped on the way. A free
// of a page not yet taken or a slot out of range is ignored. The block works
// on one beat at a time. The first-free search scans the page bitmap 64 slots
// per cycle, twice for an allocate from a partial page: once to find the
// slot, once to see if the page is now full. A finished result waits in the
// output register while the next beat is taken. Write configuration only while
// the block is idle.
module paged_bitmap_slot_allocator_unit #(
    parameter int NUM_PAGES = pbsa_pkg::NUM_PAGES_DEF,
    parameter int MAX_SLOTS = pbsa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pbsa_pkg::CFGIX_W-1:0]  cfg_index,
    input  wire logic [pbsa_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // req_size[12:0], page_index[18:13], slot_index[27:19], zeros[31:28]
    input  wire logic [pbsa_pkg::IN_DW-1:0]    s_axis_tdata,
    // func[0]
    input  wire logic [pbsa_pkg::FUNC_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status[1:0], got_page[7:2], got_slot[16:8], zeros[23:17]
    output logic [pbsa_pkg::OUT_DW-1:0]        m_axis_tdata
);

    pbsa_pkg::pbsa_cmd_t  cmd;
    pbsa_pkg::pbsa_stat_t st;
    logic [pbsa_pkg::STAT_W-1:0]  out_status;
    logic [pbsa_pkg::PGIDX_W-1:0] out_page;
    logic [pbsa_pkg::SLIDX_W-1:0] out_slot;

    pbsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pbsa_dp #(.NUM_PAGES(NUM_PAGES), .MAX_SLOTS(MAX_SLOTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_func     (s_axis_tuser),
        .in_req_size (s_axis_tdata[12:0]),
        .in_page     (s_axis_tdata[18:13]),
        .in_slot     (s_axis_tdata[27:19]),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (out_status),
        .out_page    (out_page),
        .out_slot    (out_slot)
    );

    assign m_axis_tdata = {7'd0, out_slot, out_page, out_status};

endmodule

`default_nettype wire

// ===== bench/tb_paged_bitmap_slot_allocator_unit.sv =====
`default_nettype none

module tb_paged_bitmap_slot_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES     = pbsa_pkg::NUM_PAGES_DEF;
    localparam int SLOTS     = pbsa_pkg::MAX_SLOTS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [pbsa_pkg::SLIDX_W-1:0] slot;
        logic [pbsa_pkg::PGIDX_W-1:0] page;
        logic [pbsa_pkg::STAT_W-1:0]  status;
    } grant_t;

    typedef struct {
        logic [pbsa_pkg::PGIDX_W-1:0] page;
        logic [pbsa_pkg::SLIDX_W-1:0] slot;
    } handle_t;

    // Predicts allocator grants and keeps the queue of grants still owed
    class alloc_scoreboard;
        logic [SLOTS-1:0] bitmap [PAGES];
        bit               full [PAGES];
        int unsigned      stack [PAGES];
        int unsigned      depth;
        int unsigned      fresh_used;
        int unsigned      obj_size;
        int unsigned      slots_cfg;
        int unsigned      hdr;
        grant_t           owed [$];
        handle_t          owned [$];
        int               errors;
        int               n_ok;
        int               n_big;
        int               n_nopage;
        int               n_free;

        function new();
            for (int i = 0; i < PAGES; i++)
            begin
                bitmap[i] = '0;
                full[i]   = 0;
                stack[i]  = 0;
            end
            depth = 0;
            fresh_used = 0;
            obj_size = 8;
            slots_cfg = 512;
            hdr = 1;
            errors = 0;
            n_ok = 0;
            n_big = 0;
            n_nopage = 0;
            n_free = 0;
        endfunction

        function void write_reg(logic [pbsa_pkg::CFGIX_W-1:0] idx,
                                logic [pbsa_pkg::CFG_W-1:0] v);
            case (idx)
                pbsa_pkg::REG_OBJECT_SIZE:  obj_size = 32'(v[12:0]);
                pbsa_pkg::REG_SLOTS_IN_USE: slots_cfg = 32'(v[9:0]);
                pbsa_pkg::REG_HEADER_SLOTS: hdr = 32'(v[2:0]);
                default: ;
            endcase
        endfunction

        function int unsigned eff_slots();
            int unsigned n;
            n = slots_cfg & ~(pbsa_pkg::BYTE_BITS - 1);
            if (n < pbsa_pkg::BYTE_BITS) n = pbsa_pkg::BYTE_BITS;
            if (n > SLOTS) n = SLOTS;
            return n;
        endfunction

        function int unsigned first_free(int unsigned p);
            int unsigned n;
            n = eff_slots();
            for (int unsigned s = 0; s < n; s++)
                if (!bitmap[p][s]) return s;
            return n;
        endfunction

        // Advance the state for one accepted request and queue its grant
        function void note_input(logic f, logic [pbsa_pkg::SIZE_W-1:0] req,
                                 logic [pbsa_pkg::PGIDX_W-1:0] pg,
                                 logic [pbsa_pkg::SLIDX_W-1:0] sl);
            grant_t g;
            int unsigned n, s, p;
            handle_t h;
            g = '0;
            n = eff_slots();
            if (f == pbsa_pkg::FUNC_FREE)
            begin
                n_free++;
                if (pg < fresh_used && sl < n)
                begin
                    bitmap[pg][sl] = 1'b0;
                    if (full[pg] && depth < PAGES)
                    begin
                        full[pg] = 0;
                        stack[depth] = 32'(pg);
                        depth++;
                    end
                end
            end
            else if (req > obj_size)
            begin
                g.status = pbsa_pkg::ST_TOO_BIG;
                n_big++;
            end
            else
            begin
                s = n;
                p = 0;
                // pop exhausted pages off the partial stack
                while (depth > 0)
                begin
                    p = stack[depth-1];
                    s = first_free(p);
                    if (s < n) break;
                    full[p] = 1;
                    depth--;
                end
                if (depth > 0)
                begin
                    bitmap[p][s] = 1'b1;
                    if (first_free(p) >= n)
                    begin
                        full[p] = 1;
                        depth--;
                    end
                    g.page = pbsa_pkg::PGIDX_W'(p);
                    g.slot = pbsa_pkg::SLIDX_W'(s);
                end
                else if (fresh_used < PAGES)
                begin
                    p = fresh_used;
                    fresh_used++;
                    bitmap[p] = '0;
                    for (int unsigned i = 0; i <= hdr; i++) bitmap[p][i] = 1'b1;
                    if (first_free(p) >= n)
                        full[p] = 1;
                    else
                    begin
                        full[p] = 0;
                        stack[depth] = p;
                        depth++;
                    end
                    g.page = pbsa_pkg::PGIDX_W'(p);
                    g.slot = pbsa_pkg::SLIDX_W'(hdr);
                end
                else
                    g.status = pbsa_pkg::ST_NO_PAGE;
                if (g.status == pbsa_pkg::ST_OK)
                begin
                    n_ok++;
                    h.page = g.page;
                    h.slot = g.slot;
                    owned.push_back(h);
                end
                else
                    n_nopage++;
            end
            owed.push_back(g);
        endfunction

        function void check(logic [pbsa_pkg::OUT_DW-1:0] d);
            grant_t got, want;
            got = d[16:0];
            if (owed.size() == 0)
            begin
                $error("unexpected result beat %h", d);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.page !== want.page)
            begin
                $error("got_page: expected %0d actual %0d", want.page, got.page);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $error("got_slot: expected %0d actual %0d", want.slot, got.slot);
                errors++;
            end
            if (d[23:17] !== '0)
            begin
                $error("pad bits: expected 0 actual %h", d[23:17]);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pbsa_pkg::CFGIX_W-1:0]  cfg_index;
    logic [pbsa_pkg::CFG_W-1:0]    cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [pbsa_pkg::IN_DW-1:0]    s_axis_tdata;
    logic [pbsa_pkg::FUNC_W-1:0]   s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [pbsa_pkg::OUT_DW-1:0]   m_axis_tdata;

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int idle_count;

    paged_bitmap_slot_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Receiver: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: register writes, request beats, result beats, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser[0], s_axis_tdata[12:0],
                              s_axis_tdata[18:13], s_axis_tdata[27:19]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_count <= 0;
            else if (idle_count + 1 >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    // Offer one request beat and hold it until accepted
    task automatic send_item(logic f, logic [pbsa_pkg::SIZE_W-1:0] req,
                             logic [pbsa_pkg::PGIDX_W-1:0] pg,
                             logic [pbsa_pkg::SLIDX_W-1:0] sl);
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = f;
        s_axis_tdata  = {4'b0, sl, pg, req};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_cfg(logic [pbsa_pkg::CFGIX_W-1:0] idx, int unsigned v);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = pbsa_pkg::CFG_W'(v);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_phase(int unsigned osize, int unsigned slots, int unsigned h);
        write_cfg(pbsa_pkg::REG_OBJECT_SIZE, osize);
        write_cfg(pbsa_pkg::REG_SLOTS_IN_USE, slots);
        write_cfg(pbsa_pkg::REG_HEADER_SLOTS, h);
    endtask

    // Mostly allocates and frees of owned objects, some noise
    task automatic random_items(int count, int free_pct);
        int roll;
        int k;
        handle_t h;
        logic [pbsa_pkg::SIZE_W-1:0] req;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < free_pct && sb.owned.size() > 0)
            begin
                k = $urandom_range(sb.owned.size() - 1);
                h = sb.owned[k];
                sb.owned.delete(k);
                send_item(pbsa_pkg::FUNC_FREE, pbsa_pkg::SIZE_W'($urandom),
                          h.page, h.slot);
            end
            else if (roll < free_pct + 10)
                send_item(pbsa_pkg::FUNC_FREE, pbsa_pkg::SIZE_W'($urandom),
                          pbsa_pkg::PGIDX_W'($urandom), pbsa_pkg::SLIDX_W'($urandom));
            else
            begin
                if ($urandom_range(9) == 0)
                    req = pbsa_pkg::SIZE_W'($urandom);
                else
                    req = pbsa_pkg::SIZE_W'($urandom_range(sb.obj_size));
                send_item(pbsa_pkg::FUNC_ALLOC, req,
                          pbsa_pkg::PGIDX_W'($urandom), pbsa_pkg::SLIDX_W'($urandom));
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        idle_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: size limits, header and double frees, untaken pages
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd0, '0, '0);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd8, 6'h3f, 9'h1ff);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd9, '0, '0);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd4096, '0, '0);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'h1fff, '0, '0);
        send_item(pbsa_pkg::FUNC_FREE, 13'h1fff, 6'd0, 9'd2);
        send_item(pbsa_pkg::FUNC_FREE, '0, 6'd0, 9'd2);
        send_item(pbsa_pkg::FUNC_FREE, '0, 6'd0, 9'd0);
        send_item(pbsa_pkg::FUNC_FREE, '0, 6'd63, 9'd5);
        send_item(pbsa_pkg::FUNC_FREE, '0, 6'd0, 9'd511);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd1, '0, '0);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd8, '0, '0);
        send_item(pbsa_pkg::FUNC_ALLOC, 13'd7, '0, '0);

        // Odd slot count rounds down to eight; long receiver hold-off
        set_phase(100, 13, 3);
        send_item(pbsa_pkg::FUNC_FREE, '0, 6'd0, 9'd8);
        hold_cycles = 400;
        random_items(70, 25);
        send_idle_pct = 81;
        random_items(40, 25);

        // Slot count above the maximum clips to full pages
        set_phase(1, 1023, 1);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        random_items(70, 30);

        // Shrink pages so stacked pages turn out full on the search
        set_phase(4096, 16, 7);
        send_idle_pct = 17;
        recv_stall_pct = 17;
        random_items(70, 30);

        // Every fresh page full at once, run the pool dry
        set_phase(4096, 8, 7);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_items(90, 20);
        send_item(pbsa_pkg::FUNC_FREE, '0, 6'd1, 9'd8);

        // Back to wide pages with a two-slot header
        set_phase(8, 512, 2);
        send_idle_pct = 81;
        random_items(40, 35);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        random_items(40, 35);

        drain();
        $display("covered %0d grants, %0d oversize, %0d out of pages, %0d frees",
                 sb.n_ok, sb.n_big, sb.n_nopage, sb.n_free);
        $display("pages taken %0d of %0d across six register settings",
                 sb.fresh_used, PAGES);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== paged_bitmap_slot_allocator_unit.f =====
hdl/pbsa_pkg.sv
hdl/pbsa_ram.sv
hdl/pbsa_ctrl.sv
hdl/pbsa_dp.sv
hdl/paged_bitmap_slot_allocator_unit.sv
bench/tb_paged_bitmap_slot_allocator_unit.sv
